[sv/sct_pkg.sv]
// Shared types, codes and helper functions of the shell command tokenizer.
package sct_pkg;

   // Most result words that one input byte can cause
   localparam int MAX_RES = 4;
   localparam int CNT_W   = $clog2(MAX_RES + 1);
   localparam int IDX_W   = $clog2(MAX_RES);

   // Depth of the queue between front and back end
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   // Byte codes of the special characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   typedef enum logic [3:0] {
      KIND_WORD      = 4'd0,
      KIND_QUOTED    = 4'd1,
      KIND_AND       = 4'd2,
      KIND_OR        = 4'd3,
      KIND_APPEND    = 4'd4,
      KIND_PIPE      = 4'd5,
      KIND_REDIR_OUT = 4'd6,
      KIND_REDIR_IN  = 4'd7,
      KIND_SEMICOLON = 4'd8,
      KIND_AMPERSAND = 4'd9,
      KIND_EOL       = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_AMP  = 2'd1,
      PEND_BAR  = 2'd2,
      PEND_GT   = 2'd3
   } pend_type;

   // One result word, without its run_last flag
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       has;
      logic       tend;
   } entry_type;

   // All result words caused by one input byte
   typedef struct packed {
      logic [CNT_W-1:0]               count;
      entry_type [MAX_RES-1:0]        ent;
   } bundle_type;

   function automatic entry_type make_entry(kind_type kind, logic [7:0] data,
                                            logic has, logic tend);
      entry_type e;
      e.kind = kind;
      e.data = has ? data : 8'h00;
      e.has  = has;
      e.tend = tend;
      return e;
   endfunction

   function automatic logic [7:0] pend_char(pend_type p);
      logic [7:0] c;
      case (p)
         PEND_AMP: c = CH_AMP;
         PEND_BAR: c = CH_BAR;
         PEND_GT:  c = CH_GT;
         default:  c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic kind_type single_kind(pend_type p);
      kind_type k;
      case (p)
         PEND_AMP: k = KIND_AMPERSAND;
         PEND_BAR: k = KIND_PIPE;
         PEND_GT:  k = KIND_REDIR_OUT;
         default:  k = KIND_WORD;
      endcase
      return k;
   endfunction

   function automatic kind_type double_kind(pend_type p);
      kind_type k;
      case (p)
         PEND_AMP: k = KIND_AND;
         PEND_BAR: k = KIND_OR;
         PEND_GT:  k = KIND_APPEND;
         default:  k = KIND_WORD;
      endcase
      return k;
   endfunction

endpackage

[sv/sct_front.sv]
// Front end: accepts bytes, tracks lexer state and builds the result bundle of each byte.
module sct_front
   import sct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_byte,
   input  logic       req_line_last,
   output logic       req_stall,
   input  logic       q_full,
   output logic       q_push,
   output bundle_type q_data
);

   pend_type pend_ff, pend_in;
   logic     word_ff, word_in;
   logic     quote_ff, quote_in;
   logic     single_ff, single_in;

   logic      accept;
   logic      is_ws;
   logic      do_plain;
   logic [CNT_W-1:0] n;
   entry_type [MAX_RES-1:0] slot;
   logic [7:0] c;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign c         = req_char_byte;
   assign is_ws     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

   // Walk the byte through the lexer and collect its results in order
   always_comb begin
      pend_in   = pend_ff;
      word_in   = word_ff;
      quote_in  = quote_ff;
      single_in = single_ff;
      n         = '0;
      slot      = '0;
      do_plain  = 1'b0;

      if (quote_ff) begin
         if (c == (single_ff ? CH_SQUOTE : CH_DQUOTE)) begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_QUOTED, 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
            quote_in = 1'b0;
         end else begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_QUOTED, c, 1'b1, 1'b0);
            n = n + CNT_W'(1);
         end
      end else if (pend_ff != PEND_NONE) begin
         if (c == pend_char(pend_ff)) begin
            slot[n[IDX_W-1:0]] = make_entry(double_kind(pend_ff), 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
         end else begin
            slot[n[IDX_W-1:0]] = make_entry(single_kind(pend_ff), 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
            do_plain = 1'b1;
         end
         pend_in = PEND_NONE;
      end else begin
         do_plain = 1'b1;
      end

      // Ordinary byte outside quotes: no operator pending, or one it does not pair
      if (do_plain) begin
         if (is_ws || (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_AMP) ||
             (c == CH_BAR) || (c == CH_GT) || (c == CH_LT) || (c == CH_SEMI)) begin
            if (word_in) begin
               slot[n[IDX_W-1:0]] = make_entry(KIND_WORD, 8'h00, 1'b0, 1'b1);
               n = n + CNT_W'(1);
               word_in = 1'b0;
            end
         end
         if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            quote_in  = 1'b1;
            single_in = (c == CH_SQUOTE);
         end else if (c == CH_AMP) begin
            pend_in = PEND_AMP;
         end else if (c == CH_BAR) begin
            pend_in = PEND_BAR;
         end else if (c == CH_GT) begin
            pend_in = PEND_GT;
         end else if (c == CH_LT) begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_REDIR_IN, 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
         end else if (c == CH_SEMI) begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_SEMICOLON, 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
         end else if (!is_ws) begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_WORD, c, 1'b1, 1'b0);
            n = n + CNT_W'(1);
            word_in = 1'b1;
         end
      end

      // Close everything that is open at the end of the line
      if (req_line_last) begin
         if (pend_in != PEND_NONE) begin
            slot[n[IDX_W-1:0]] = make_entry(single_kind(pend_in), 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
         end
         if (word_in) begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_WORD, 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
         end
         if (quote_in) begin
            slot[n[IDX_W-1:0]] = make_entry(KIND_QUOTED, 8'h00, 1'b0, 1'b1);
            n = n + CNT_W'(1);
         end
         slot[n[IDX_W-1:0]] = make_entry(KIND_EOL, 8'h00, 1'b0, 1'b0);
         n = n + CNT_W'(1);
         pend_in   = PEND_NONE;
         word_in   = 1'b0;
         quote_in  = 1'b0;
         single_in = 1'b0;
      end
   end

   // Push only bytes that cause results
   assign q_push       = accept && (n != '0);
   assign q_data.count = n;
   assign q_data.ent   = slot;

   // Advance lexer state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= PEND_NONE;
         word_ff   <= 1'b0;
         quote_ff  <= 1'b0;
         single_ff <= 1'b0;
      end else if (accept) begin
         pend_ff   <= pend_in;
         word_ff   <= word_in;
         quote_ff  <= quote_in;
         single_ff <= single_in;
      end
   end

endmodule

[sv/sct_queue.sv]
// Short bundle queue that decouples the front end from the back end.
module sct_queue
   import sct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       not_empty,
   output bundle_type head
);

   bundle_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in;
   logic [QPTR_W-1:0]    rd_ff, rd_in;
   logic [QPTR_W:0]      cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (cnt_ff == (QPTR_W + 1)'(QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Step pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + (QPTR_W + 1)'(1);
         2'b01:   cnt_in = cnt_ff - (QPTR_W + 1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold pushed bundles
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[sv/sct_back.sv]
// Back end: pops queued bundles, sends their words one per cycle unless stalled.
module sct_back
   import sct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  bundle_type q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   output logic [3:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic       rsp_token_end,
   output logic       rsp_run_last,
   input  logic       rsp_stall
);

   bundle_type        cur_ff;
   logic              cur_vld_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              out_vld_ff;
   entry_type         out_ff;
   logic              out_last_ff;

   logic      out_free;
   logic      adv;
   logic      last_ent;
   logic      cur_done;
   entry_type sel;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign adv      = cur_vld_ff && out_free;
   assign last_ent = ({1'b0, idx_ff} == (cur_ff.count - CNT_W'(1)));
   assign cur_done = adv && last_ent;
   assign q_pop    = q_not_empty && (!cur_vld_ff || cur_done);
   assign sel      = cur_ff.ent[idx_ff];

   // Load the next bundle or step through the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (q_pop) begin
         cur_vld_ff <= 1'b1;
         idx_ff     <= '0;
      end else if (cur_done) begin
         cur_vld_ff <= 1'b0;
      end else if (adv) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
   end

   // Output register: fill when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff      <= sel;
         out_last_ff <= last_ent;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_data_byte = out_ff.data;
   assign rsp_has_byte  = out_ff.has;
   assign rsp_token_end = out_ff.tend;
   assign rsp_run_last  = out_last_ff;

endmodule

[sv/shell_command_tokenizer.sv]
// Top level of the shell command tokenizer: front end, bundle queue and back end.
//
// Usage: send one command-line byte per word on the req_ channel, with
// req_line_last high on the final byte of each line. The block returns a
// stream of result words on the rsp_ channel: word and quoted content
// bytes, token end marks, operators (&& || >> | > < ; &) and one
// end-of-line word per line. rsp_run_last flags the final result of a byte.
// Bytes that cause no result (whitespace outside a word, a held operator
// byte) give no output at all.
// Path: the first result of a byte goes through the bundle queue, the
// current-bundle register and the output register of the back end.
// Throughput: one result word per cycle while rsp_stall is low, set by the
// single output register of the back end; a byte causes 0 to 4 results.
// Bytes are taken one per cycle while the two-entry bundle queue has room.
// Reset clears the lexer state, the queue and the output register.
// When the receiver stalls, the output word holds; the queue fills and then
// req_stall rises until space frees up.
module shell_command_tokenizer
   import sct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_byte,
   input  logic       req_line_last,
   output logic       req_stall,
   output logic       rsp_valid,
   output logic [3:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic       rsp_token_end,
   output logic       rsp_run_last,
   input  logic       rsp_stall
);

   logic       q_push;
   bundle_type q_in;
   logic       q_full;
   logic       q_pop;
   logic       q_not_empty;
   bundle_type q_head;

   sct_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_char_byte (req_char_byte),
      .req_line_last (req_line_last),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_in)
   );

   sct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   sct_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_has_byte  (rsp_has_byte),
      .rsp_token_end (rsp_token_end),
      .rsp_run_last  (rsp_run_last),
      .rsp_stall     (rsp_stall)
   );

   // A content byte never closes a token
   a_byte_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_has_byte && rsp_token_end))
      else $error("content word also marks token end");

   // Content bytes belong only to word or quoted tokens
   a_byte_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_byte) |->
         ((rsp_kind == KIND_WORD) || (rsp_kind == KIND_QUOTED)))
      else $error("content byte on an operator word");

   // End of line is always the last result of its byte
   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_EOL)) |-> (rsp_run_last && !rsp_token_end))
      else $error("end-of-line word not last of its run");

   // A pushed bundle never arrives while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("bundle pushed into full queue");

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the shell command tokenizer with a token scoreboard.
module tb_top;
   import sct_pkg::*;

   // One expected result word
   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       has;
      logic       tend;
      logic       run_last;
   } lex_word_type;

   // Track lexer state and the result words still owed by the block
   class token_ledger;
      pend_type     held_op;
      bit           in_word;
      bit           in_quote;
      bit           single_q;
      lex_word_type owed[$];
      lex_word_type run[$];
      int           faults;

      function new();
         clear_state();
         faults = 0;
      endfunction

      function void clear_state();
         held_op  = PEND_NONE;
         in_word  = 0;
         in_quote = 0;
         single_q = 0;
      endfunction

      function void put(kind_type k, logic [7:0] d, logic h, logic t);
         lex_word_type w;
         w.kind     = k;
         w.data     = h ? d : 8'h00;
         w.has      = h;
         w.tend     = t;
         w.run_last = 1'b0;
         run.insert(run.size(), w);
      endfunction

      function void end_word();
         if (in_word) begin
            put(KIND_WORD, 8'h00, 1'b0, 1'b1);
            in_word = 0;
         end
      endfunction

      // Emit a held operator as its one-character form
      function void release_op();
         case (held_op)
            PEND_AMP: put(KIND_AMPERSAND, 8'h00, 1'b0, 1'b1);
            PEND_BAR: put(KIND_PIPE, 8'h00, 1'b0, 1'b1);
            PEND_GT:  put(KIND_REDIR_OUT, 8'h00, 1'b0, 1'b1);
            default: ;
         endcase
         held_op = PEND_NONE;
      endfunction

      // Handle a byte outside quotes with no operator held
      function void lex_plain(logic [7:0] c);
         if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            end_word();
         end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            end_word();
            in_quote = 1;
            single_q = (c == CH_SQUOTE);
         end else if (c == CH_AMP) begin
            end_word();
            held_op = PEND_AMP;
         end else if (c == CH_BAR) begin
            end_word();
            held_op = PEND_BAR;
         end else if (c == CH_GT) begin
            end_word();
            held_op = PEND_GT;
         end else if (c == CH_LT) begin
            end_word();
            put(KIND_REDIR_IN, 8'h00, 1'b0, 1'b1);
         end else if (c == CH_SEMI) begin
            end_word();
            put(KIND_SEMICOLON, 8'h00, 1'b0, 1'b1);
         end else begin
            put(KIND_WORD, c, 1'b1, 1'b0);
            in_word = 1;
         end
      endfunction

      // Note an accepted input word and queue the results it causes
      function void take_byte(logic [7:0] c, logic last);
         logic       pair;
         kind_type   pk;
         logic [7:0] qc;
         run.delete();
         if (in_quote) begin
            qc = single_q ? CH_SQUOTE : CH_DQUOTE;
            if (c == qc) begin
               put(KIND_QUOTED, 8'h00, 1'b0, 1'b1);
               in_quote = 0;
            end else begin
               put(KIND_QUOTED, c, 1'b1, 1'b0);
            end
         end else if (held_op != PEND_NONE) begin
            pair = 1'b0;
            pk   = KIND_WORD;
            case (held_op)
               PEND_AMP: begin pair = (c == CH_AMP); pk = KIND_AND; end
               PEND_BAR: begin pair = (c == CH_BAR); pk = KIND_OR; end
               PEND_GT:  begin pair = (c == CH_GT);  pk = KIND_APPEND; end
               default: ;
            endcase
            if (pair) begin
               put(pk, 8'h00, 1'b0, 1'b1);
               held_op = PEND_NONE;
            end else begin
               release_op();
               lex_plain(c);
            end
         end else begin
            lex_plain(c);
         end
         // Close everything at the end of the line
         if (last) begin
            release_op();
            end_word();
            if (in_quote) put(KIND_QUOTED, 8'h00, 1'b0, 1'b1);
            put(KIND_EOL, 8'h00, 1'b0, 1'b0);
            clear_state();
         end
         if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
         foreach (run[i]) owed.insert(owed.size(), run[i]);
      endfunction

      // Compare one accepted result word with the oldest expectation
      function void match_word(logic [3:0] k, logic [7:0] d, logic h, logic t, logic rl);
         lex_word_type w;
         if (owed.size() == 0) begin
            $error("result word with none expected: kind %0d data %0h", k, d);
            faults++;
            return;
         end
         w = owed.pop_front();
         if (k !== w.kind) begin
            $error("kind: expected %0d, actual %0d", w.kind, k);
            faults++;
         end
         if (d !== w.data) begin
            $error("data_byte: expected %0h, actual %0h", w.data, d);
            faults++;
         end
         if (h !== w.has) begin
            $error("has_byte: expected %0b, actual %0b", w.has, h);
            faults++;
         end
         if (t !== w.tend) begin
            $error("token_end: expected %0b, actual %0b", w.tend, t);
            faults++;
         end
         if (rl !== w.run_last) begin
            $error("run_last: expected %0b, actual %0b", w.run_last, rl);
            faults++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic [7:0] req_char_byte;
   logic       req_line_last;
   logic       req_stall;
   logic       rsp_valid;
   logic [3:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_byte;
   logic       rsp_token_end;
   logic       rsp_run_last;
   logic       rsp_stall;

   token_ledger sb = new();
   int          idle_max = 9;
   bit          hold_req = 0;
   int          sent = 0;

   shell_command_tokenizer uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_char_byte (req_char_byte),
      .req_line_last (req_line_last),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_has_byte  (rsp_has_byte),
      .rsp_token_end (rsp_token_end),
      .rsp_run_last  (rsp_run_last),
      .rsp_stall     (rsp_stall)
   );

   always #5 clock = ~clock;

   // Offer one input word after a random gap and hold it until accepted
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      req_line_last <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_byte(c, last);
      sent++;
   endtask

   // Drop valid right at the step of the last acceptance
   task automatic idle_sender();
      req_valid <= 1'b0;
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Draw a byte biased toward lexer-relevant characters
   function automatic logic [7:0] pick_byte();
      int         r;
      int         sel;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         c = 8'h61 + 8'($urandom_range(0, 25));
      end else if (r < 55) begin
         sel = $urandom_range(0, 6);
         c = (sel == 6) ? CH_SPACE : 8'(9 + sel);
      end else if (r < 77) begin
         case ($urandom_range(0, 4))
            0:       c = CH_AMP;
            1:       c = CH_BAR;
            2:       c = CH_GT;
            3:       c = CH_LT;
            default: c = CH_SEMI;
         endcase
      end else if (r < 87) begin
         c = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // Send a random line; repeat the previous byte now and then to form pairs
   task automatic random_line(input int len);
      logic [7:0] c;
      logic [7:0] prev;
      prev = 8'h00;
      for (int i = 0; i < len; i++) begin
         c = (i > 0 && $urandom_range(0, 4) == 0) ? prev : pick_byte();
         send_byte(c, i == len - 1);
         prev = c;
      end
   endtask

   // Receive result words with random stalls; honor a long hold-off on request
   initial begin
      int n;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_req) begin
            n = 150;
            hold_req = 0;
         end else begin
            n = $urandom_range(0, idle_max);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.match_word(rsp_kind, rsp_data_byte, rsp_has_byte, rsp_token_end, rsp_run_last);
      end
   end

   // Main stimulus: reset, directed lines, random lines, drain
   initial begin
      bit did_hold;
      bit did_pause;
      did_hold      = 0;
      did_pause     = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_byte = 8'h00;
      req_line_last = 1'b0;
      rsp_stall     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Operators, pairs, operator at line end, quotes and byte extremes
      send_line("&&");
      send_line("||>>");
      send_line("|;<");
      send_line(">x&");
      send_line("'a\"'");
      send_line("\"\"");
      send_line("w\"");
      send_line("\"b");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_SPACE, 1'b1);

      while (sent < 264) begin
         idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         if (!did_hold && sent >= 100) begin
            // Stall the output for a long stretch while bytes keep coming
            did_hold = 1;
            hold_req = 1;
            idle_max = 0;
            random_line(12);
            random_line(12);
         end else if (!did_pause && sent >= 200) begin
            // Pause input until every result has come back
            did_pause = 1;
            idle_sender();
            while (sb.owed.size() != 0) @(posedge clock);
            random_line($urandom_range(1, 12));
         end else begin
            random_line($urandom_range(1, 12));
         end
      end
      idle_sender();

      // Wait for the last results, then watch for strays
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.faults == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
sv/sct_pkg.sv
sv/sct_front.sv
sv/sct_queue.sv
sv/sct_back.sv
sv/shell_command_tokenizer.sv
tb/tb_top.sv
